@@ src/ctf_pkg.sv @@
// Package for the CRC-16 trailer framer: CRC constants, beat type and the
// byte-wide CRC-16/CCITT update. No dependencies.
`default_nettype none

package ctf_pkg;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam int          BYTE_W    = 8;
    localparam int          CRC_W     = 16;

    // Position of an output beat within the results of one input item.
    typedef enum logic [1:0] {
        BEAT_DATA = 2'd0,
        BEAT_HIGH = 2'd1,
        BEAT_LOW  = 2'd2
    } t_beat;

    // Advance the CRC over one byte, MSB first.
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/crc16_trailer_framer.sv @@
// Top level of the CRC-16 trailer framer: passes payload bytes through and
// appends a two-byte CRC-16/CCITT trailer per frame. Depends on ctf_pkg.
//
//  channel | direction | tdata         | tuser       | tlast
//  --------+-----------+---------------+-------------+----------
//  s       | in        | data_byte[7:0]| cmd         | frame_end
//  m       | out       | out_byte[7:0] | is_trailer  | out_last
//
// A payload byte passes through the input stage and takes one beat on the
// output; a byte that closes a frame, or an empty-frame command, holds the
// input stage for three or two beats respectively while the trailer drains.
// The output register is the only limit on rate: one beat per cycle when the
// sink is ready. Reset (synchronous, active low) empties both stages and sets
// the running CRC to 0xFFFF. A stall on the m side holds the output register
// and, once the input stage is also full, drops s tready.
`default_nettype none

module crc16_trailer_framer
    import ctf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // slave side
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [BYTE_W-1:0] i_s_tdata,   // [7:0] data_byte
    input  wire logic              i_s_tuser,   // [0] cmd
    input  wire logic              i_s_tlast,   // frame_end
    // master side
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [BYTE_W-1:0]      o_m_tdata,   // [7:0] out_byte
    output logic                   o_m_tuser,   // [0] is_trailer
    output logic                   o_m_tlast    // out_last
);

    // running CRC over the open frame
    logic [CRC_W-1:0]  r_crc, n_crc;

    // input stage: one accepted item and the beat it is about to emit
    logic              r_stg_valid;
    t_beat             r_stg_beat;
    logic [BYTE_W-1:0] r_stg_byte;
    logic [CRC_W-1:0]  r_stg_crc;     // trailer value for this item
    logic              r_stg_end;     // item closes a frame

    // output register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_trl;
    logic              r_out_last;

    logic              s_accept;
    logic              out_load;
    logic              beat_final;
    logic [CRC_W-1:0]  crc_upd;
    logic [BYTE_W-1:0] beat_byte;

    assign crc_upd = crc16_byte(r_crc, i_s_tdata);

    // The last beat of an item is the low trailer byte, or the payload beat
    // of a byte that does not close its frame.
    assign beat_final = (r_stg_beat == BEAT_LOW) || ((r_stg_beat == BEAT_DATA) && !r_stg_end);

    // Move a beat whenever the output register is empty or being drained.
    assign out_load   = r_stg_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_stg_valid || (out_load && beat_final);
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        unique case (r_stg_beat)
            BEAT_DATA: beat_byte = r_stg_byte;
            BEAT_HIGH: beat_byte = r_stg_crc[CRC_W-1:BYTE_W];
            BEAT_LOW:  beat_byte = r_stg_crc[BYTE_W-1:0];
            default:   beat_byte = r_stg_byte;
        endcase
    end

    // Restart the CRC whenever a trailer is scheduled, else fold in the byte.
    always_comb begin
        n_crc = r_crc;
        if (s_accept) begin
            if (i_s_tuser || i_s_tlast) begin
                n_crc = CRC_INIT;
            end else begin
                n_crc = crc_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_stg_valid <= 1'b0;
            r_stg_beat  <= BEAT_DATA;
            r_out_valid <= 1'b0;
        end else begin
            r_crc <= n_crc;

            // input stage
            if (s_accept) begin
                r_stg_valid <= 1'b1;
                r_stg_byte  <= i_s_tdata;
                r_stg_end   <= i_s_tuser || i_s_tlast;
                if (i_s_tuser) begin
                    r_stg_beat <= BEAT_HIGH;
                    r_stg_crc  <= r_crc;
                end else begin
                    r_stg_beat <= BEAT_DATA;
                    r_stg_crc  <= crc_upd;
                end
            end else if (out_load) begin
                if (beat_final) begin
                    r_stg_valid <= 1'b0;
                end else if (r_stg_beat == BEAT_DATA) begin
                    r_stg_beat <= BEAT_HIGH;
                end else begin
                    r_stg_beat <= BEAT_LOW;
                end
            end

            // output register
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= beat_byte;
                r_out_trl   <= (r_stg_beat != BEAT_DATA);
                r_out_last  <= (r_stg_beat == BEAT_LOW);
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tuser  = r_out_trl;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

@@ src/ctf_checker.sv @@
// Port-level checker for the CRC-16 trailer framer and its bind to the top
// level. Uses only the top level's ports.
`default_nettype none

module ctf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] o_m_tdata,
    input wire logic       o_m_tuser,
    input wire logic       o_m_tlast
);

    // set after a high trailer byte leaves, cleared when the low byte leaves
    logic r_hi_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_pending <= 1'b0;
        end else if (o_m_tvalid && i_m_tready) begin
            r_hi_pending <= o_m_tuser && !o_m_tlast;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output beat changed while stalled");

    a_last_is_trailer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser)
        else $error("frame end marked on a payload beat");

    a_low_follows_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_hi_pending |-> o_m_tuser && o_m_tlast)
        else $error("high trailer byte not followed by low trailer byte");

    a_no_orphan_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> r_hi_pending)
        else $error("low trailer byte without a high trailer byte");

endmodule

bind crc16_trailer_framer ctf_checker u_ctf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
